/* rtl/core/wpms_pkg.sv */
// wpms_pkg: shared types, codes and binary32 helpers for the weighted pair merge/select block.
// Used by wpms_front, wpms_fifo, wpms_back and the top level. No dependencies.
package wpms_pkg;

  localparam int unsigned WpmsQueueDepth = 2;

  localparam logic [31:0] RandomTop = 32'h3f7f_ffff;  // 0.99999994f
  localparam logic [31:0] PosInf    = 32'h7f80_0000;
  localparam logic [31:0] U32All    = 32'hffff_ffff;

  typedef enum logic [1:0] {
    SEL_FIRST  = 2'd0,
    SEL_SECOND = 2'd1,
    SEL_NONE   = 2'd2
  } sel_e;

  typedef enum logic [1:0] {
    STAT_INVALID  = 2'd0,
    STAT_VALID_Z  = 2'd1,
    STAT_VALID_P  = 2'd2,
    STAT_RESERVED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ALIGN,
    ST_NORM,
    ST_SUBN,
    ST_PACK,
    ST_DONE,
    ST_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    OP_UCW,
    OP_P1,
    OP_P2,
    OP_MASS,
    OP_SUM,
    OP_SCALE
  } op_e;

  // One classified proposal as it travels from front to back.
  typedef struct packed {
    logic        slot;
    logic        pre_valid;   // status and operand checks passed
    logic [31:0] conf;
    logic [31:0] w;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] jac;
    logic [31:0] mis;
    logic [31:0] rnd;         // random already clamped to [0, RandomTop]
  } wpms_item_t;

  // Significand with hidden bit (subnormals and zero have none).
  function automatic logic [23:0] fp_sig(input logic [31:0] f);
    fp_sig = {(f[30:23] != 8'd0), f[22:0]};
  endfunction

  // Effective exponent field: subnormals use 1.
  function automatic logic [7:0] fp_exp(input logic [31:0] f);
    fp_exp = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
  endfunction

  function automatic logic fp_finite(input logic [31:0] f);
    fp_finite = (f[30:23] != 8'hff);
  endfunction

  function automatic logic fp_finite_nonneg(input logic [31:0] f);
    fp_finite_nonneg = fp_finite(f) && (!f[31] || (f[30:0] == 31'd0));
  endfunction

  function automatic logic fp_finite_pos(input logic [31:0] f);
    fp_finite_pos = fp_finite(f) && !f[31] && (f[30:0] != 31'd0);
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    sat_add32 = s[32] ? U32All : s[31:0];
  endfunction

endpackage

/* rtl/core/wpms_front.sv */
// wpms_front: classifies one incoming proposal (status, finiteness, signs) and clamps the random.
// Depends on wpms_pkg.
module wpms_front (
  input  logic                 pair_slot_i,
  input  logic [1:0]           status_i,
  input  logic [31:0]          confidence_i,
  input  logic [31:0]          scaled_weight_i,
  input  logic [31:0]          source_target_i,
  input  logic [31:0]          target_target_i,
  input  logic [31:0]          jacobian_i,
  input  logic [31:0]          mis_weight_i,
  input  logic [31:0]          winner_random_i,
  output wpms_pkg::wpms_item_t item_o
);
  import wpms_pkg::*;

  logic st_ok, ops_ok, tgt_ok, tgt_zero;
  logic r_nan;

  always_comb begin
    tgt_zero = (target_target_i[30:0] == 31'd0);
    st_ok    = (status_i == STAT_VALID_Z) || (status_i == STAT_VALID_P);
    ops_ok   = fp_finite_nonneg(scaled_weight_i) && fp_finite_pos(source_target_i) &&
               fp_finite_nonneg(target_target_i) && fp_finite_pos(jacobian_i) &&
               fp_finite_nonneg(mis_weight_i);
    tgt_ok   = (status_i == STAT_VALID_Z) ? tgt_zero : !tgt_zero;
    r_nan    = (winner_random_i[30:23] == 8'hff) && (winner_random_i[22:0] != 23'd0);

    item_o.slot      = pair_slot_i;
    item_o.pre_valid = st_ok && ops_ok && tgt_ok;
    item_o.conf      = confidence_i;
    item_o.w         = scaled_weight_i;
    item_o.src       = source_target_i;
    item_o.tgt       = target_target_i;
    item_o.jac       = jacobian_i;
    item_o.mis       = mis_weight_i;
    // NaN and negatives (incl. -0) read as zero; anything above the top clamps down
    if (r_nan || winner_random_i[31]) begin
      item_o.rnd = 32'd0;
    end else if (winner_random_i > RandomTop) begin
      item_o.rnd = RandomTop;
    end else begin
      item_o.rnd = winner_random_i;
    end
  end

endmodule

/* rtl/core/wpms_fifo.sv */
// wpms_fifo: short register queue of classified proposals between front and back.
// Depends on wpms_pkg.
module wpms_fifo #(
  parameter int unsigned Depth = wpms_pkg::WpmsQueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wpms_pkg::wpms_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output wpms_pkg::wpms_item_t head_o
);
  import wpms_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wpms_item_t          mem_q [Depth];
  logic [IdxW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/core/wpms_back.sv */
// wpms_back: sequencer with bit-serial divider, 24x24 multiplier, aligning adder and a
// shift-per-cycle normalize/round unit; holds the pair state and the output register.
// Depends on wpms_pkg.
module wpms_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  wpms_pkg::wpms_item_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          total_mass_o,
  output logic [1:0]           selected_o,
  output logic [31:0]          out_confidence_o,
  output logic [1:0]           valid_mask_o
);
  import wpms_pkg::*;

  localparam int unsigned DivW = 74;   // 24-bit significand followed by 50 zero bits
  localparam int unsigned AddW = 27;   // significand plus 3 guard bits

  back_state_e state_q, state_d;
  op_e         op_q, op_d;
  wpms_item_t  item_q, item_d;

  logic [31:0] ucw_q, ucw_d, opa_q, opa_d, opb_q, opb_d;
  logic [DivW-1:0] dv_q, dv_d;
  logic [23:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;

  logic [DivW-1:0]    rs_q, rs_d;
  logic signed [10:0] re_q, re_d;
  logic        rst_q, rst_d, rsg_q, rsg_d;

  logic [AddW-1:0] aa_q, aa_d, ab_q, ab_d;
  logic [7:0]  ae_q, ae_d, be_q, be_d;
  logic        jam_q, jam_d;

  logic [31:0] mass_q, mass_d, cconf_q, cconf_d;
  logic        cval_q, cval_d;
  logic [31:0] held_mass_q, held_mass_d, held_conf_q, held_conf_d;
  logic        held_val_q, held_val_d;
  logic [31:0] total_q, total_d;
  logic [1:0]  sel_q, sel_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_total_q, out_total_d, out_conf_q, out_conf_d;
  logic [1:0]  out_sel_q, out_sel_d, out_mask_q, out_mask_d;

  // divider step
  logic [24:0] div_r2;
  logic        div_ge;
  logic [24:0] div_diff;
  // multiplier
  logic [47:0] prod;
  // pack
  logic [23:0] keep;
  logic        round_up, ovf, big;
  logic signed [10:0] fexp;
  logic [30:0] sum31;
  logic [31:0] res;
  // adder setup
  logic [7:0]  eh, em;
  logic [AddW:0] add_sum;

  assign out_valid_o      = out_valid_q;
  assign total_mass_o     = out_total_q;
  assign selected_o       = out_sel_q;
  assign out_confidence_o = out_conf_q;
  assign valid_mask_o     = out_mask_q;

  always_comb begin
    div_r2   = {rem_q, dv_q[DivW-1]};
    div_ge   = (div_r2 >= {1'b0, fp_sig(item_q.src)});
    div_diff = div_r2 - {1'b0, fp_sig(item_q.src)};
    prod     = fp_sig(opa_q) * fp_sig(opb_q);

    keep     = rs_q[24:1];
    round_up = rs_q[0] && (rst_q || keep[0]);
    fexp     = re_q + 11'sd151;
    big      = keep[23] && (fexp >= 11'sd255);
    sum31    = {(keep[23] ? fexp[7:0] : 8'd0), keep[22:0]} + 31'(round_up);
    ovf      = big || (sum31[30:23] == 8'hff);
    res      = ovf ? PosInf : {rsg_q, sum31};

    eh       = fp_exp(held_mass_q);
    em       = fp_exp(mass_q);
    add_sum  = {1'b0, aa_q} + {1'b0, ab_q[AddW-1:1], ab_q[0] | jam_q};
  end

  always_comb begin
    state_d = state_q;   op_d = op_q;       item_d = item_q;
    ucw_d = ucw_q;       opa_d = opa_q;     opb_d = opb_q;
    dv_d = dv_q;         rem_d = rem_q;     cnt_d = cnt_q;
    rs_d = rs_q;         re_d = re_q;       rst_d = rst_q;    rsg_d = rsg_q;
    aa_d = aa_q;         ab_d = ab_q;       ae_d = ae_q;      be_d = be_q;   jam_d = jam_q;
    mass_d = mass_q;     cconf_d = cconf_q; cval_d = cval_q;
    held_mass_d = held_mass_q; held_conf_d = held_conf_q; held_val_d = held_val_q;
    total_d = total_q;   sel_d = sel_q;
    out_total_d = out_total_q; out_conf_d = out_conf_q;
    out_sel_d = out_sel_q;     out_mask_d = out_mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          item_d = head_i;
          if (!head_i.pre_valid) begin
            mass_d = 32'd0; cconf_d = 32'd0; cval_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            dv_d  = {fp_sig(head_i.w), 50'd0};
            rem_d = '0;
            cnt_d = '0;
            re_d  = 11'(fp_exp(head_i.w)) - 11'(fp_exp(head_i.src)) - 11'sd50;
            rsg_d = head_i.w[31] ^ head_i.src[31];
            op_d  = OP_UCW;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? div_diff[23:0] : div_r2[23:0];
        dv_d  = {dv_q[DivW-2:0], div_ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DivW - 1)) begin
          rs_d  = {dv_q[DivW-2:0], div_ge};
          rst_d = (rem_d != 24'd0);
          state_d = ST_NORM;
        end
      end
      ST_MUL: begin
        rs_d  = DivW'(prod);
        re_d  = 11'(fp_exp(opa_q)) + 11'(fp_exp(opb_q)) - 11'sd300;
        rst_d = 1'b0;
        rsg_d = opa_q[31] ^ opb_q[31];
        state_d = ST_NORM;
      end
      ST_ALIGN: begin
        if (be_q < ae_q) begin
          if (ab_q == '0) begin
            be_d = ae_q;
          end else begin
            ab_d  = ab_q >> 1;
            jam_d = jam_q | ab_q[0];
            be_d  = be_q + 8'd1;
          end
        end else begin
          rs_d  = DivW'(add_sum);
          re_d  = 11'(ae_q) - 11'sd153;
          rst_d = 1'b0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (rs_q[DivW-1:25] != '0) begin
          rs_d  = rs_q >> 1;
          rst_d = rst_q | rs_q[0];
          re_d  = re_q + 11'sd1;
        end else if (!rs_q[24] && (rs_q != '0)) begin
          rs_d = rs_q << 1;
          re_d = re_q - 11'sd1;
        end else begin
          state_d = ST_SUBN;
        end
      end
      ST_SUBN: begin
        // below the normal range: shift into subnormal position
        if ((re_q < -11'sd150) && (rs_q != '0)) begin
          rs_d  = rs_q >> 1;
          rst_d = rst_q | rs_q[0];
          re_d  = re_q + 11'sd1;
        end else begin
          state_d = ST_PACK;
        end
      end
      ST_PACK: begin
        unique case (op_q)
          OP_UCW, OP_P1, OP_P2, OP_MASS: begin
            if (ovf) begin
              mass_d = 32'd0; cconf_d = 32'd0; cval_d = 1'b0;
              state_d = ST_DONE;
            end else if (op_q == OP_MASS) begin
              mass_d = res; cconf_d = item_q.conf; cval_d = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_MUL;
              if (op_q == OP_UCW) begin
                ucw_d = res; opa_d = item_q.mis; opb_d = item_q.tgt; op_d = OP_P1;
              end else if (op_q == OP_P1) begin
                opa_d = res; opb_d = ucw_q; op_d = OP_P2;
              end else begin
                opa_d = res; opb_d = item_q.jac; op_d = OP_MASS;
              end
            end
          end
          OP_SUM: begin
            total_d = res;
            if (ovf || (res[30:0] == 31'd0)) begin
              sel_d = SEL_NONE;
              state_d = ST_EMIT;
            end else begin
              opa_d = item_q.rnd; opb_d = res; op_d = OP_SCALE;
              state_d = ST_MUL;
            end
          end
          OP_SCALE: begin
            sel_d = (res[30:0] < held_mass_q[30:0]) ? SEL_FIRST : SEL_SECOND;
            state_d = ST_EMIT;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!item_q.slot) begin
          held_mass_d = mass_q; held_conf_d = cconf_q; held_val_d = cval_q;
          state_d = ST_IDLE;
        end else begin
          // larger exponent goes to the A side, the other aligns down
          if (eh >= em) begin
            aa_d = {fp_sig(held_mass_q), 3'b000}; ae_d = eh;
            ab_d = {fp_sig(mass_q), 3'b000};      be_d = em;
          end else begin
            aa_d = {fp_sig(mass_q), 3'b000};      ae_d = em;
            ab_d = {fp_sig(held_mass_q), 3'b000}; be_d = eh;
          end
          jam_d = 1'b0;
          rsg_d = held_mass_q[31] & mass_q[31];
          op_d  = OP_SUM;
          state_d = ST_ALIGN;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_sel_d   = sel_q;
          out_conf_d  = sat_add32(held_conf_q, cconf_q);
          out_mask_d  = {cval_q, held_val_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_mass_q <= 32'd0;
      held_conf_q <= 32'd0;
      held_val_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_mass_q <= held_mass_d;
      held_conf_q <= held_conf_d;
      held_val_q  <= held_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;       item_q <= item_d;
    ucw_q <= ucw_d;     opa_q <= opa_d;     opb_q <= opb_d;
    dv_q <= dv_d;       rem_q <= rem_d;     cnt_q <= cnt_d;
    rs_q <= rs_d;       re_q <= re_d;       rst_q <= rst_d;    rsg_q <= rsg_d;
    aa_q <= aa_d;       ab_q <= ab_d;       ae_q <= ae_d;      be_q <= be_d;   jam_q <= jam_d;
    mass_q <= mass_d;   cconf_q <= cconf_d; cval_q <= cval_d;
    total_q <= total_d; sel_q <= sel_d;
    out_total_q <= out_total_d; out_conf_q <= out_conf_d;
    out_sel_q <= out_sel_d;     out_mask_q <= out_mask_d;
  end

endmodule

/* rtl/core/weighted_pair_merge_select.sv */
// weighted_pair_merge_select: pairs binary32 sample proposals and picks a weighted winner.
// The back end takes one proposal at a time; a completing one adds alignment, sum and scale,
//   and subnormal operands lengthen the work. The bit-serial divider and the one-bit-per-cycle
//   normalize/round unit dominate the time. The front keeps taking items until the queue fills.
//   Reset (async, active low) clears the held proposal to +0/invalid.
module weighted_pair_merge_select #(
  parameter int unsigned QueueDepth = wpms_pkg::WpmsQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        pair_slot_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] confidence_i,
  input  logic [31:0] scaled_weight_i,
  input  logic [31:0] source_target_i,
  input  logic [31:0] target_target_i,
  input  logic [31:0] jacobian_i,
  input  logic [31:0] mis_weight_i,
  input  logic [31:0] winner_random_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] total_mass_o,
  output logic [1:0]  selected_o,
  output logic [31:0] out_confidence_o,
  output logic [1:0]  valid_mask_o
);
  import wpms_pkg::*;

  wpms_item_t front_item, head_item;
  logic       q_full, q_empty, q_pop;

  // Front: classification only; a transfer lands directly in the queue.
  wpms_front u_front (
    .pair_slot_i     (pair_slot_i),
    .status_i        (status_i),
    .confidence_i    (confidence_i),
    .scaled_weight_i (scaled_weight_i),
    .source_target_i (source_target_i),
    .target_target_i (target_target_i),
    .jacobian_i      (jacobian_i),
    .mis_weight_i    (mis_weight_i),
    .winner_random_i (winner_random_i),
    .item_o          (front_item)
  );

  // Input stalls only when the queue is full.
  assign in_stall_o = q_full;

  wpms_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  // Back: mass mapping, pair merge and winner pick, with its own output register.
  wpms_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .head_i           (head_item),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .total_mass_o     (total_mass_o),
    .selected_o       (selected_o),
    .out_confidence_o (out_confidence_o),
    .valid_mask_o     (valid_mask_o)
  );

endmodule

/* sim/weighted_pair_merge_select_test.sv */
// Testbench for weighted_pair_merge_select: directed, backpressure and random pair streams.
// Predicts each pair result with a binary32 model built on real arithmetic plus exact rounding.
// Depends on wpms_pkg (sel_e, status_e, RandomTop) and the top-level RTL module.
module weighted_pair_merge_select_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wpms_pkg::*;

  localparam int unsigned CycleLimit = 6_000_000;
  localparam int unsigned DrainCycles = 1200;  // covers worst subnormal latency plus sum/scale

  // binary32 constants used by the directed part
  localparam logic [31:0] F_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NZERO = 32'h8000_0000;
  localparam logic [31:0] F_HALF = 32'h3f00_0000;
  localparam logic [31:0] F_ONE = 32'h3f80_0000;
  localparam logic [31:0] F_TWO = 32'h4000_0000;
  localparam logic [31:0] F_NEG_ONE = 32'hbf80_0000;
  localparam logic [31:0] F_MAX = 32'h7f7f_ffff;
  localparam logic [31:0] F_INF = 32'h7f80_0000;
  localparam logic [31:0] F_NAN = 32'h7fc0_0000;
  localparam logic [31:0] F_MIN_SUB = 32'h0000_0001;
  localparam logic [31:0] F_MIN_NORM = 32'h0080_0000;
  localparam logic [31:0] F_HUGE = 32'h7f00_0000;

  typedef struct {
    logic        slot;
    logic [1:0]  status;
    logic [31:0] conf;
    logic [31:0] w;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] jac;
    logic [31:0] mis;
    logic [31:0] rnd;
  } proposal_t;

  typedef struct {
    logic [31:0] total;
    sel_e        sel;
    logic [31:0] conf;
    logic [1:0]  mask;
  } pair_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        pair_slot;
  logic [1:0]  status;
  logic [31:0] confidence;
  logic [31:0] scaled_weight;
  logic [31:0] source_target;
  logic [31:0] target_target;
  logic [31:0] jacobian;
  logic [31:0] mis_weight;
  logic [31:0] winner_random;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] total_mass;
  logic [1:0]  selected;
  logic [31:0] out_confidence;
  logic [1:0]  valid_mask;

  // predictor copy of the held proposal
  logic [31:0] held_mass_q;
  logic [31:0] held_conf_q;
  logic        held_valid_q;

  pair_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           quiet;        // no idling on either side
  int unsigned  hold_cycles;  // long receiver hold-off request

  weighted_pair_merge_select uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pair_slot_i     (pair_slot),
    .status_i        (status),
    .confidence_i    (confidence),
    .scaled_weight_i (scaled_weight),
    .source_target_i (source_target),
    .target_target_i (target_target),
    .jacobian_i      (jacobian),
    .mis_weight_i    (mis_weight),
    .winner_random_i (winner_random),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .total_mass_o    (total_mass),
    .selected_o      (selected),
    .out_confidence_o(out_confidence),
    .valid_mask_o    (valid_mask)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // binary32 arithmetic: operands go to double exactly, the op runs in double,
  // then one correct round-to-nearest-even back to binary32. Double precision is
  // wide enough that this double rounding is harmless for +, *, /.
  // ---------------------------------------------------------------------------
  function automatic real f32_to_real(input logic [31:0] f);
    real mag;
    if (f[30:23] == 8'hff) begin
      // infinity or NaN keeps its class in double
      mag = $bitstoreal({1'b0, 11'h7ff, f[22:0], 29'd0});
    end else if (f[30:23] == 8'd0) begin
      // subnormal or zero: mantissa times 2^-149, both exact
      mag = real'(f[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
    end else begin
      mag = $bitstoreal({1'b0, 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
    end
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [31:0] real_to_f32(input real x);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] mag;
    int          fe;
    int          sh;
    d = $realtobits(x);
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    if (d[62:52] == 11'h7ff) return {d[63], F_INF[30:0]};
    fe = int'(d[62:52]) - 1023 + 127;
    if (fe >= 255) return {d[63], F_INF[30:0]};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (fe >= 1) ? 29 : 29 + 1 - fe;
    if (sh > 60) return {d[63], 31'd0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (fe >= 1) begin
      // carry out of the significand bumps the exponent, up to infinity
      mag = (32'(fe) << 23) + q[31:0] - 32'h0080_0000;
      if (mag >= F_INF) mag = F_INF;
    end else begin
      mag = q[31:0];
    end
    return {d[63], mag[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_div(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) / f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic bit is_fin(input logic [31:0] f);
    return f[30:23] != 8'hff;
  endfunction

  // -0 counts as zero
  function automatic bit is_fin_nonneg(input logic [31:0] f);
    return is_fin(f) && (!f[31] || f[30:0] == 31'd0);
  endfunction

  function automatic bit is_fin_pos(input logic [31:0] f);
    return is_fin(f) && !f[31] && f[30:0] != 31'd0;
  endfunction

  // Classify one proposal and compute its mass; invalid ones carry +0 and no confidence.
  function automatic void map_proposal(input proposal_t p, output logic ok,
                                       output logic [31:0] mass, output logic [31:0] conf);
    logic [31:0] ucw;
    logic [31:0] m;
    bit          tgt_zero;
    ok = 1'b0;
    mass = F_ZERO;
    conf = 32'd0;
    tgt_zero = (p.tgt[30:0] == 31'd0);
    if (p.status != STAT_VALID_Z && p.status != STAT_VALID_P) return;
    if (!is_fin_nonneg(p.w) || !is_fin_pos(p.src) || !is_fin_nonneg(p.tgt) ||
        !is_fin_pos(p.jac) || !is_fin_nonneg(p.mis)) return;
    if ((p.status == STAT_VALID_Z && !tgt_zero) || (p.status == STAT_VALID_P && tgt_zero))
      return;
    ucw = f32_div(p.w, p.src);
    m = f32_mul(f32_mul(f32_mul(p.mis, p.tgt), ucw), p.jac);
    if (!is_fin_nonneg(ucw) || !is_fin_nonneg(m)) return;
    ok = 1'b1;
    mass = m;
    conf = p.conf;
  endfunction

  // Update the held proposal or queue the pair result for one accepted transfer.
  task automatic predict_pair(input proposal_t p);
    logic         ok;
    logic [31:0]  mass;
    logic [31:0]  conf;
    logic [31:0]  r;
    logic [32:0]  csum;
    pair_result_t res;
    map_proposal(p, ok, mass, conf);
    if (!p.slot) begin
      held_mass_q = mass;
      held_conf_q = conf;
      held_valid_q = ok;
      return;
    end
    res.total = f32_add(held_mass_q, mass);
    res.sel = SEL_NONE;
    if (is_fin_pos(res.total)) begin
      r = p.rnd;
      if (r[31] || (r[30:23] == 8'hff && r[22:0] != 23'd0)) r = F_ZERO;  // NaN or negative
      else if (r > RandomTop) r = RandomTop;
      res.sel = (f32_to_real(f32_mul(r, res.total)) < f32_to_real(held_mass_q)) ?
                SEL_FIRST : SEL_SECOND;
    end
    csum = {1'b0, held_conf_q} + {1'b0, conf};
    res.conf = csum[32] ? 32'hffff_ffff : csum[31:0];
    res.mask = {ok, held_valid_q};
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: called right after a rising edge; returns right after the edge at
  // which the transfer happened (plus any idle gap).
  // ---------------------------------------------------------------------------
  task automatic send_proposal(input proposal_t p);
    int unsigned gap;
    in_valid <= 1'b1;
    pair_slot <= p.slot;
    status <= p.status;
    confidence <= p.conf;
    scaled_weight <= p.w;
    source_target <= p.src;
    target_target <= p.tgt;
    jacobian <= p.jac;
    mis_weight <= p.mis;
    winner_random <= p.rnd;
    do @(posedge clk); while (in_stall);
    predict_pair(p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic proposal_t mk(input logic slot, input logic [1:0] st,
                                   input logic [31:0] conf, input logic [31:0] w,
                                   input logic [31:0] src, input logic [31:0] tgt,
                                   input logic [31:0] jac, input logic [31:0] mis,
                                   input logic [31:0] rnd);
    proposal_t p;
    p.slot = slot; p.status = st; p.conf = conf; p.w = w; p.src = src;
    p.tgt = tgt; p.jac = jac; p.mis = mis; p.rnd = rnd;
    return p;
  endfunction

  // Mostly moderate positive values, with a spread of special encodings.
  function automatic logic [31:0] rand_f32();
    logic [22:0] man;
    man = 23'($urandom());
    case ($urandom_range(0, 24))
      0: return F_ZERO;
      1: return F_NZERO;
      2: return $urandom_range(0, 1) ? F_INF : 32'hff80_0000;
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hff, man | 23'd1};  // NaN
      4: return {1'b1, 8'($urandom_range(100, 150)), man};
      5: return {1'b0, 8'd0, man};
      6: return {1'b0, 8'($urandom_range(240, 254)), man};
      7: return {1'b0, 8'($urandom_range(1, 30)), man};
      8: return $urandom();
      default: return {1'b0, 8'($urandom_range(112, 142)), man};
    endcase
  endfunction

  function automatic logic [31:0] rand_random();
    if ($urandom_range(0, 9) == 0) return rand_f32();
    if ($urandom_range(0, 29) == 0) return RandomTop;
    return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom())};
  endfunction

  function automatic proposal_t rand_proposal(input logic slot);
    proposal_t p;
    int unsigned k;
    p.slot = slot;
    k = $urandom_range(0, 9);
    p.status = (k < 7) ? STAT_VALID_P : (k == 7) ? STAT_VALID_Z : 2'($urandom());
    case ($urandom_range(0, 5))
      0: p.conf = $urandom();
      1: p.conf = 32'hffff_ffff - $urandom_range(0, 255);
      default: p.conf = $urandom_range(0, 4095);
    endcase
    // mostly clean operands so that pairs reach the arithmetic
    if ($urandom_range(0, 3) != 0) begin
      p.w = {1'b0, 8'($urandom_range(110, 140)), 23'($urandom())};
      p.src = {1'b0, 8'($urandom_range(110, 140)), 23'($urandom())};
      p.tgt = {1'b0, 8'($urandom_range(110, 140)), 23'($urandom())};
      p.jac = {1'b0, 8'($urandom_range(115, 135)), 23'($urandom())};
      p.mis = {1'b0, 8'($urandom_range(120, 127)), 23'($urandom())};
      if ($urandom_range(0, 15) == 0) p.w = rand_f32();
      if ($urandom_range(0, 15) == 0) p.src = rand_f32();
      if ($urandom_range(0, 15) == 0) p.jac = rand_f32();
      if ($urandom_range(0, 15) == 0) p.mis = rand_f32();
    end else begin
      p.w = rand_f32(); p.src = rand_f32(); p.tgt = rand_f32();
      p.jac = rand_f32(); p.mis = rand_f32();
    end
    if (p.status == STAT_VALID_Z && $urandom_range(0, 3) != 0)
      p.tgt = $urandom_range(0, 1) ? F_NZERO : F_ZERO;
    p.rnd = rand_random();
    return p;
  endfunction

  // Mostly well-formed first/second pairs, some lone or repeated proposals.
  task automatic send_random_stream(input int unsigned n_items);
    int unsigned n;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 6) != 0) begin
        send_proposal(rand_proposal(1'b0));
        send_proposal(rand_proposal(1'b1));
        n += 2;
      end else begin
        send_proposal(rand_proposal(1'($urandom())));
        n += 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, an optional long hold-off, none when quiet.
  // ---------------------------------------------------------------------------
  int unsigned stall_burst;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_burst = 0;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_burst != 0) begin
      out_stall <= 1'b1;
      stall_burst = stall_burst - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_burst = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every transfer out is matched against the oldest prediction.
  task automatic report_mismatch(input string what, input pair_result_t exp_r);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected total=%h sel=%0d conf=%h mask=%b, ",
                "got total=%h sel=%0d conf=%h mask=%b"},
               what, exp_r.total, exp_r.sel, exp_r.conf, exp_r.mask,
               total_mass, selected, out_confidence, valid_mask);
  endtask

  always @(posedge clk) begin
    pair_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        exp_r = '{total: 32'd0, sel: SEL_NONE, conf: 32'd0, mask: 2'd0};
        report_mismatch("unexpected result", exp_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (total_mass !== exp_r.total || selected !== exp_r.sel ||
            out_confidence !== exp_r.conf || valid_mask !== exp_r.mask)
          report_mismatch("field", exp_r);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[weighted_pair_merge_select] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // second without first after reset pairs with the reset proposal
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd7, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_HALF));
    // both invalid statuses: total 0, no selection
    send_proposal(mk(1'b0, STAT_INVALID, 32'd9, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_HALF));
    send_proposal(mk(1'b1, STAT_RESERVED, 32'd9, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_HALF));
    // confidence saturation, NaN random
    send_proposal(mk(1'b0, STAT_VALID_P, 32'hffff_ffff, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE,
                     F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd5, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_NAN));
    // negative zeros count as zero; negative random
    send_proposal(mk(1'b0, STAT_VALID_Z, 32'd3, F_NZERO, F_ONE, F_NZERO, F_ONE, F_NZERO,
                     F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd4, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE,
                     F_NEG_ONE));
    // wrongly signed targets, repeated first, random of infinity
    send_proposal(mk(1'b0, STAT_VALID_Z, 32'd1, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd2, F_ONE, F_TWO, F_ZERO, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd6, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_INF));
    // total overflows to infinity
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd1, F_MAX, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd1, F_MAX, F_ONE, F_ONE, F_ONE, F_ONE, F_HALF));
    // zero divisor, quotient rounding to zero, infinite jacobian, top random
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd1, F_ONE, F_ZERO, F_ONE, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd8, F_MIN_SUB, F_TWO, F_ONE, F_ONE, F_ONE,
                     F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd8, F_ONE, F_TWO, F_ONE, F_INF, F_ONE,
                     RandomTop));
    // quotient far below the subnormal range: mass rounds to zero
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd1, F_MIN_NORM, F_HUGE, F_ONE, F_ONE, F_ONE,
                     F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd1, F_ONE, F_TWO, F_ONE, F_ONE, F_ONE, F_ONE));
    // NaN mis weight, negative target
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd1, F_ONE, F_TWO, F_ONE, F_ONE, F_NAN, F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd1, F_ONE, F_TWO, F_NEG_ONE, F_ONE, F_ONE,
                     F_HALF));
    // held proposal survives a completed pair
    send_proposal(mk(1'b0, STAT_VALID_P, 32'd10, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd20, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO));
    send_proposal(mk(1'b1, STAT_VALID_P, 32'd30, F_TWO, F_ONE, F_ONE, F_ONE, F_ONE,
                     RandomTop));
  endtask

  // Receiver holds off long enough for the queue to fill and stall the input.
  task automatic test_backpressure();
    int unsigned i;
    hold_cycles = 2000;
    for (i = 0; i < 12; i++) begin
      send_proposal(rand_proposal(1'b0));
      send_proposal(rand_proposal(1'b1));
    end
  endtask

  task automatic test_random();
    send_random_stream(1380);
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    send_random_stream(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    pair_slot = 1'b0;
    status = STAT_INVALID;
    confidence = 32'd0;
    scaled_weight = 32'd0;
    source_target = 32'd0;
    target_target = 32'd0;
    jacobian = 32'd0;
    mis_weight = 32'd0;
    winner_random = 32'd0;
    held_mass_q = F_ZERO;
    held_conf_q = 32'd0;
    held_valid_q = 1'b0;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();
    test_no_idle();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[weighted_pair_merge_select] OK");
    end else begin
      $display("[weighted_pair_merge_select] ERROR");
    end
    $finish;
  end

endmodule
